// ----- hdl/modular_exponentiation_defines.svh -----
// Assertion macros shared by the block's modules.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define ME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next.
`define ME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 64'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 64'd1;

  // Control broadcast to every multiplier-bit cell.
  typedef struct packed {
    logic load;
    logic shift;
  } modexp_cell_ctl_t;

endpackage

// ----- hdl/modexp_cell.sv -----
// ----------------------------------------------------------------------------
// modexp_cell
// One bit of the multiplier operand; loads in parallel, shifts to its upper
// neighbour each multiply step.
// ----------------------------------------------------------------------------
module modexp_cell
  import modexp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  modexp_cell_ctl_t ctl_i,
  input  logic             load_bit_i,
  input  logic             shift_in_i,
  output logic             bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (ctl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctl_i.shift) begin
      bit_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

// ----- hdl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus by square-and-multiply over a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one base value per request (tdata); m_axis returns one
//    result per request. cfg_* writes modulus (index 0) or exponent (index 1);
//    a zero modulus write is dropped. The user must write them only while the
//    block is idle; the block itself does not enforce this.
//  - Each modular product is shift-and-add: one multiplier bit per cycle,
//    taken from the top of a chain of OPERAND_WIDTH bit cells; the base is
//    first reduced by one product.
//  - Then per exponent bit, msb first: a squaring, plus a multiply by the
//    reduced base where the bit is one; the result then goes to output.
//  - One request at a time: s_axis_tready is high only while idle. A finished
//    result sits in the output register, so a new request is taken while the
//    receiver stalls; a second result then waits until the first is taken.
//  - Reset: modulus 1, exponent 5, no output pending.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [63:0] base_value
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata    // [63:0] power_result
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1; // base mod m, as 1 * base
  localparam logic [2:0] ST_SQ   = 3'd2; // r = r * r
  localparam logic [2:0] ST_MU   = 3'd3; // r = r * b
  localparam logic [2:0] ST_FIN  = 3'd4; // result waits for output register

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - y;
    add_mod = (x >= gap) ? (x - gap) : (x + y);
  endfunction

  logic [2:0]    state_q, state_d;
  logic [W-1:0]  mod_q, mod_d;
  logic [W-1:0]  exp_q, exp_d;
  logic [W-1:0]  e_q, e_d;       // exponent snapshot, msb first
  logic [W-1:0]  r_q, r_d;
  logic [W-1:0]  b_q, b_d;       // reduced base
  logic [W-1:0]  a_q, a_d;       // multiplicand
  logic [W-1:0]  acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;   // multiply step
  logic [CW-1:0] eidx_q, eidx_d; // exponent bit
  logic [W-1:0]  out_q, out_d;
  logic          ov_q, ov_d;

  modexp_cell_ctl_t cell_ctl;
  logic [W-1:0]     cell_load;
  logic [W-1:0]     cell_bit;

  logic [W-1:0] one;
  logic [W-1:0] dbl, step;
  logic         last_step;

  // multiplier-bit chain: cell k shifts into cell k+1, top cell feeds the step
  for (genvar k = 0; k < W; k++) begin : g_cell
    modexp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl),
      .load_bit_i (cell_load[k]),
      .shift_in_i ((k == 0) ? 1'b0 : cell_bit[(k == 0) ? 0 : k-1]),
      .bit_o      (cell_bit[k])
    );
  end

  assign one = (mod_q == W'(1)) ? '0 : W'(1);

  // one shift-and-add step of the modular product
  assign dbl       = add_mod(acc_q, acc_q, mod_q);
  assign step      = cell_bit[W-1] ? add_mod(dbl, a_q, mod_q) : dbl;
  assign last_step = (cnt_q == CW'(W-1));

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = DATA_W'(out_q);

  always_comb begin
    state_d  = state_q;
    mod_d    = mod_q;
    exp_d    = exp_q;
    e_d      = e_q;
    r_d      = r_q;
    b_d      = b_q;
    a_d      = a_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    eidx_d   = eidx_q;
    out_d    = out_q;
    ov_d     = ov_q;
    cell_ctl = '{load: 1'b0, shift: 1'b0};
    cell_load = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MODULUS) begin
        if (cfg_data_i[W-1:0] != '0) begin
          mod_d = cfg_data_i[W-1:0];
        end
      end else if (cfg_index_i == CFG_EXPONENT) begin
        exp_d = cfg_data_i[W-1:0];
      end
    end

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          e_d       = exp_q;
          a_d       = one;
          acc_d     = '0;
          cnt_d     = '0;
          eidx_d    = CW'(W-1);
          cell_ctl  = '{load: 1'b1, shift: 1'b0};
          cell_load = s_axis_tdata[W-1:0];
          state_d   = ST_RED;
        end
      end
      ST_RED, ST_SQ, ST_MU: begin
        acc_d    = step;
        cnt_d    = cnt_q + CW'(1);
        cell_ctl = '{load: 1'b0, shift: 1'b1};
        if (last_step) begin
          acc_d = '0;
          cnt_d = '0;
          r_d   = step;
          if (state_q == ST_RED) begin
            b_d       = step;
            r_d       = one;
            a_d       = one;
            cell_ctl  = '{load: 1'b1, shift: 1'b0};
            cell_load = one;
            state_d   = ST_SQ;
          end else if (state_q == ST_SQ && e_q[W-1]) begin
            a_d       = step;
            cell_ctl  = '{load: 1'b1, shift: 1'b0};
            cell_load = b_q;
            state_d   = ST_MU;
          end else if (eidx_q == '0) begin
            state_d = ST_FIN;
          end else begin
            // next exponent bit: square the new r
            eidx_d    = eidx_q - CW'(1);
            e_d       = {e_q[W-2:0], 1'b0};
            a_d       = step;
            cell_ctl  = '{load: 1'b1, shift: 1'b0};
            cell_load = step;
            state_d   = ST_SQ;
          end
        end
      end
      ST_FIN: begin
        if (!ov_q || m_axis_tready) begin
          out_d   = r_q;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q   <= W'(1);
      exp_q   <= W'(5);
      cnt_q   <= '0;
      eidx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mod_q   <= mod_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      eidx_q  <= eidx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    r_q   <= r_d;
    b_q   <= b_d;
    a_q   <= a_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  `ME_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request overlap")
  `ME_ASSERT(a_mod_nonzero, mod_q != '0, "modulus is zero")
  `ME_ASSERT(a_acc_reduced, (state_q == ST_IDLE) || (state_q == ST_FIN) || (acc_q < mod_q), "accumulator not reduced")
  `ME_ASSERT(a_r_reduced, (state_q != ST_FIN) || (r_q < mod_q), "result not reduced")

endmodule
